### sv/spq_pkg.sv
`default_nettype none

package spq_pkg;

  // Request kinds.
  localparam logic [1:0] KIND_ENQUEUE = 2'd0;
  localparam logic [1:0] KIND_POP     = 2'd1;
  localparam logic [1:0] KIND_REMOVE  = 2'd2;
  localparam logic [1:0] KIND_PEEK    = 2'd3;

  // Result status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_EMPTY     = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
  localparam logic [1:0] STATUS_FULL      = 2'd3;

  // Operation broadcast to every cell of the chain.
  localparam logic [1:0] CELL_HOLD   = 2'd0;
  localparam logic [1:0] CELL_INSERT = 2'd1;
  localparam logic [1:0] CELL_SHIFT  = 2'd2;
  localparam logic [1:0] CELL_REMOVE = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] letter;
    logic [7:0] priority_req;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] out_letter;
    logic [7:0] out_priority;
    logic [4:0] count;
    logic       empty_res;
  } out_t;

endpackage

`default_nettype wire

### sv/spq_cell.sv
`default_nettype none

module spq_cell #(
  parameter int PRIORITY_BITS = 8
) (
  input  wire logic                     clk_i,
  input  wire logic [1:0]               op_i,
  input  wire logic                     occ_i,
  input  wire logic                     prev_lt_i,
  input  wire logic [7:0]               new_letter_i,
  input  wire logic [PRIORITY_BITS-1:0] new_prio_i,
  input  wire logic [7:0]               left_letter_i,
  input  wire logic [PRIORITY_BITS-1:0] left_prio_i,
  input  wire logic [7:0]               right_letter_i,
  input  wire logic [PRIORITY_BITS-1:0] right_prio_i,
  output logic      [7:0]               letter_o,
  output logic      [PRIORITY_BITS-1:0] prio_o,
  output logic                          lt_o,
  output logic                          hit_o
);

  logic [7:0]               letter_q, letter_d;
  logic [PRIORITY_BITS-1:0] prio_q, prio_d;
  logic                     ge;

  // Entries are sorted, so the cells holding a smaller priority form a prefix
  // and the first cell that is not smaller sits right after that prefix.
  assign lt_o  = occ_i && (prio_q < new_prio_i);
  assign ge    = occ_i && !lt_o;
  assign hit_o = ge && prev_lt_i && (prio_q == new_prio_i);

  always_comb begin
    letter_d = letter_q;
    prio_d   = prio_q;
    case (op_i)
      spq_pkg::CELL_INSERT: begin
        if (!lt_o) begin
          if (prev_lt_i) begin
            letter_d = new_letter_i;
            prio_d   = new_prio_i;
          end else begin
            letter_d = left_letter_i;
            prio_d   = left_prio_i;
          end
        end
      end
      spq_pkg::CELL_SHIFT: begin
        letter_d = right_letter_i;
        prio_d   = right_prio_i;
      end
      spq_pkg::CELL_REMOVE: begin
        // The matching entry is overwritten as everything behind it moves one place forward.
        if (ge) begin
          letter_d = right_letter_i;
          prio_d   = right_prio_i;
        end
      end
      default: begin
        letter_d = letter_q;
        prio_d   = prio_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    letter_q <= letter_d;
    prio_q   <= prio_d;
  end

  assign letter_o = letter_q;
  assign prio_o   = prio_q;

endmodule

`default_nettype wire

### sv/sorted_priority_queue_unit.sv
// Sorted priority queue built as a chain of entry cells.
//
// Input channel (in_valid_i/in_ready_o/in_data_i) carries one request per
// transaction: enqueue, pop head, remove first entry of a given priority, or
// peek. The head is the entry with the smallest priority; equal priorities
// leave last in, first out. Each request yields exactly one result on the
// output channel (out_valid_o/out_ready_i/out_data_o) with status, the
// removed or head entry, the entry count and an empty flag.
//
// out_valid_o rises in the cycle after acceptance. Throughput is one
// transaction per cycle: every cell compares its own priority against the
// request at once and moves its entry to a neighbor in the same edge, and
// the result register accepts a new request whenever it is empty or being
// read in that cycle.
//
// Reset clears the entry count and the result valid flag; cell contents are
// not cleared and are never read before being written. When the receiver
// stalls, the result is held and in_ready_o drops until it is taken.
`default_nettype none

module sorted_priority_queue_unit #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire spq_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output spq_pkg::out_t      out_data_o
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [CW-1:0]            count_q, count_d;
  logic                     out_valid_q;
  spq_pkg::out_t            out_q, out_d;
  logic                     accept;
  logic [1:0]               op;
  logic [PRIORITY_BITS-1:0] req_prio;
  logic                     is_empty, is_full, found;

  logic [7:0]               cell_letter [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] cell_prio   [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]   cell_lt, cell_hit, cell_occ;
  logic [7:0]               hit_letter;
  logic [PRIORITY_BITS-1:0] hit_prio;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign req_prio   = PRIORITY_BITS'(in_data_i.priority_req);
  assign is_empty   = (count_q == '0);
  assign is_full    = (count_q == CW'(QUEUE_DEPTH));
  assign found      = |cell_hit;

  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    logic                     prev_lt;
    logic [7:0]               left_letter, right_letter;
    logic [PRIORITY_BITS-1:0] left_prio, right_prio;

    assign cell_occ[k] = (count_q > CW'(k));

    if (k == 0) begin : g_head
      assign prev_lt     = 1'b1;
      assign left_letter = in_data_i.letter;
      assign left_prio   = req_prio;
    end else begin : g_body
      assign prev_lt     = cell_lt[k-1];
      assign left_letter = cell_letter[k-1];
      assign left_prio   = cell_prio[k-1];
    end

    if (k == QUEUE_DEPTH - 1) begin : g_tail
      assign right_letter = '0;
      assign right_prio   = '0;
    end else begin : g_inner
      assign right_letter = cell_letter[k+1];
      assign right_prio   = cell_prio[k+1];
    end

    spq_cell #(
      .PRIORITY_BITS(PRIORITY_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .op_i          (op),
      .occ_i         (cell_occ[k]),
      .prev_lt_i     (prev_lt),
      .new_letter_i  (in_data_i.letter),
      .new_prio_i    (req_prio),
      .left_letter_i (left_letter),
      .left_prio_i   (left_prio),
      .right_letter_i(right_letter),
      .right_prio_i  (right_prio),
      .letter_o      (cell_letter[k]),
      .prio_o        (cell_prio[k]),
      .lt_o          (cell_lt[k]),
      .hit_o         (cell_hit[k])
    );
  end

  // At most one cell reports a hit, so an OR over masked entries selects it.
  always_comb begin
    hit_letter = '0;
    hit_prio   = '0;
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      if (cell_hit[k]) begin
        hit_letter = hit_letter | cell_letter[k];
        hit_prio   = hit_prio | cell_prio[k];
      end
    end
  end

  always_comb begin
    op      = spq_pkg::CELL_HOLD;
    count_d = count_q;
    out_d   = '0;
    case (in_data_i.kind)
      spq_pkg::KIND_ENQUEUE: begin
        if (is_full) begin
          out_d.status = spq_pkg::STATUS_FULL;
        end else begin
          op      = spq_pkg::CELL_INSERT;
          count_d = count_q + CW'(1);
        end
      end
      spq_pkg::KIND_POP: begin
        if (is_empty) begin
          out_d.status = spq_pkg::STATUS_EMPTY;
        end else begin
          op                 = spq_pkg::CELL_SHIFT;
          count_d            = count_q - CW'(1);
          out_d.out_letter   = cell_letter[0];
          out_d.out_priority = 8'(cell_prio[0]);
        end
      end
      spq_pkg::KIND_REMOVE: begin
        if (is_empty) begin
          out_d.status = spq_pkg::STATUS_EMPTY;
        end else if (!found) begin
          out_d.status = spq_pkg::STATUS_NOT_FOUND;
        end else begin
          op                 = spq_pkg::CELL_REMOVE;
          count_d            = count_q - CW'(1);
          out_d.out_letter   = hit_letter;
          out_d.out_priority = 8'(hit_prio);
        end
      end
      default: begin
        if (is_empty) begin
          out_d.status = spq_pkg::STATUS_EMPTY;
        end else begin
          out_d.out_letter   = cell_letter[0];
          out_d.out_priority = 8'(cell_prio[0]);
        end
      end
    endcase
    out_d.count     = 5'(count_d);
    out_d.empty_res = (count_d == '0);
    if (!accept) begin
      op      = spq_pkg::CELL_HOLD;
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### sv/spq_checker.sv
`default_nettype none

module spq_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_ready_o,
  input wire spq_pkg::in_t  in_data_i,
  input wire logic          out_valid_o,
  input wire logic          out_ready_i,
  input wire spq_pkg::out_t out_data_o
);

  // A result that is not taken stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Every accepted request shows its result on the next cycle.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("result missing one cycle after a request");

  // The empty flag agrees with the reported count.
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.empty_res == (out_data_o.count == 5'd0)))
    else $error("empty flag disagrees with count");

  // A refused enqueue only happens on a full queue, and an empty status
  // reports no entry.
  a_status_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == spq_pkg::STATUS_FULL)
      |-> out_data_o.count == 5'(QUEUE_DEPTH))
    else $error("full status with room left");

  a_status_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == spq_pkg::STATUS_EMPTY)
      |-> out_data_o.empty_res && (out_data_o.out_letter == 8'd0)
          && (out_data_o.out_priority == 8'd0))
    else $error("empty status with an entry reported");

endmodule

bind sorted_priority_queue_unit spq_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_spq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

`default_nettype wire

### sim/sorted_priority_queue_unit_tb.sv
`default_nettype none

module sorted_priority_queue_unit_tb;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH   = 16;
  localparam int PRIORITY_BITS = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 5000;
  localparam int END_CYCLES    = 16;
  localparam int MAX_REPORTS   = 10;

  // Mirror of the queue contents plus the list of results still owed by the block.
  class spq_scoreboard;
    logic [7:0]  held_letter[QUEUE_DEPTH];
    logic [7:0]  held_prio[QUEUE_DEPTH];
    int unsigned held_count   = 0;
    int unsigned peak_count   = 0;
    int unsigned mismatches   = 0;
    int unsigned checked      = 0;
    int unsigned status_seen[4] = '{0, 0, 0, 0};
    out_t        owed_results[$];

    function int unsigned pending();
      return owed_results.size();
    endfunction

    function logic [7:0] stored_priority(int unsigned idx);
      return held_prio[idx];
    endfunction

    function void drop_slot(int unsigned pos);
      for (int unsigned i = pos; i + 1 < held_count; i++) begin
        held_letter[i] = held_letter[i + 1];
        held_prio[i]   = held_prio[i + 1];
      end
      held_count--;
    endfunction

    function void note_request(in_t req);
      out_t        res;
      int unsigned pos;
      res = '0;
      res.status = STATUS_OK;
      if (req.kind == KIND_ENQUEUE) begin
        if (held_count >= QUEUE_DEPTH) begin
          res.status = STATUS_FULL;
        end else begin
          pos = 0;
          while (pos < held_count && held_prio[pos] < req.priority_req) pos++;
          for (int unsigned i = held_count; i > pos; i--) begin
            held_letter[i] = held_letter[i - 1];
            held_prio[i]   = held_prio[i - 1];
          end
          held_letter[pos] = req.letter;
          held_prio[pos]   = req.priority_req;
          held_count++;
        end
      end else if (held_count == 0) begin
        res.status = STATUS_EMPTY;
      end else begin
        case (req.kind)
          KIND_POP: begin
            res.out_letter   = held_letter[0];
            res.out_priority = held_prio[0];
            drop_slot(0);
          end
          KIND_REMOVE: begin
            pos = 0;
            while (pos < held_count && held_prio[pos] != req.priority_req) pos++;
            if (pos >= held_count) begin
              res.status = STATUS_NOT_FOUND;
            end else begin
              res.out_letter   = held_letter[pos];
              res.out_priority = held_prio[pos];
              drop_slot(pos);
            end
          end
          default: begin
            res.out_letter   = held_letter[0];
            res.out_priority = held_prio[0];
          end
        endcase
      end
      res.count     = 5'(held_count);
      res.empty_res = (held_count == 0);
      if (held_count > peak_count) peak_count = held_count;
      status_seen[res.status]++;
      owed_results.push_back(res);
    endfunction

    function void check_result(out_t got);
      out_t want;
      checked++;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: status=%0d letter=%02h prio=%02h count=%0d empty=%0b",
                   got.status, got.out_letter, got.out_priority, got.count, got.empty_res);
        return;
      end
      want = owed_results.pop_front();
      if (got.status !== want.status || got.out_letter !== want.out_letter ||
          got.out_priority !== want.out_priority || got.count !== want.count ||
          got.empty_res !== want.empty_res) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("mismatch on result %0d:", checked);
          $display("  expected status=%0d letter=%02h prio=%02h count=%0d empty=%0b",
                   want.status, want.out_letter, want.out_priority, want.count,
                   want.empty_res);
          $display("  actual   status=%0d letter=%02h prio=%02h count=%0d empty=%0b",
                   got.status, got.out_letter, got.out_priority, got.count, got.empty_res);
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  spq_scoreboard sb;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_seq      = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned sent_total    = 0;

  sorted_priority_queue_unit #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PRIORITY_BITS(PRIORITY_BITS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Receiver side. A long hold-off is requested by bumping hold_seq.
  always @(negedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input in_t req);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(req);
    sent_total++;
  endtask

  task automatic send_fields(input logic [1:0] kind, input logic [7:0] letter,
                             input logic [7:0] prio);
    in_t req;
    req.kind         = kind;
    req.letter       = letter;
    req.priority_req = prio;
    send_request(req);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Priorities cluster at both ends of the range so that ties and matches happen often.
  function automatic in_t make_request(int unsigned enq_weight);
    in_t req;
    req.letter = 8'($urandom);
    if ($urandom_range(99) < enq_weight) req.kind = KIND_ENQUEUE;
    else req.kind = 2'($urandom_range(1, 3));
    if ($urandom_range(99) < 35)
      req.priority_req = 8'($urandom_range(0, 3)) | ($urandom_range(0, 1) ? 8'hFC : 8'h00);
    else
      req.priority_req = 8'($urandom);
    if (req.kind == KIND_REMOVE && sb.held_count != 0 && $urandom_range(99) < 65)
      req.priority_req = sb.stored_priority($urandom_range(0, sb.held_count - 1));
    return req;
  endfunction

  task automatic send_random(input int unsigned n, input bit with_hold);
    int unsigned enq_weight;
    enq_weight = 50;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 3))
          0: enq_weight = 25;
          1: enq_weight = 50;
          2: enq_weight = 75;
          default: enq_weight = 90;
        endcase
      end
      if (with_hold && i == n / 3) hold_seq++;
      send_request(make_request(enq_weight));
    end
  endtask

  initial begin
    sb = new;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 32;
    recv_idle_pct = 86;
    // Requests on an empty queue, then ties, a miss and a fill past the top.
    send_fields(KIND_POP,     8'h11, 8'h00);
    send_fields(KIND_REMOVE,  8'h22, 8'hFF);
    send_fields(KIND_PEEK,    8'h33, 8'h00);
    send_fields(KIND_ENQUEUE, 8'h00, 8'h00);
    send_fields(KIND_ENQUEUE, 8'hFF, 8'hFF);
    send_fields(KIND_ENQUEUE, 8'hA5, 8'hFF);
    send_fields(KIND_PEEK,    8'h00, 8'h00);
    send_fields(KIND_REMOVE,  8'h00, 8'hFF);
    send_fields(KIND_REMOVE,  8'h00, 8'h4D);
    for (int unsigned i = 0; i < 14; i++)
      send_fields(KIND_ENQUEUE, 8'(8'h5A ^ (i * 29)), 8'(i * 19));
    send_fields(KIND_ENQUEUE, 8'hC3, 8'h01);
    send_fields(KIND_REMOVE,  8'h00, 8'hFF);
    send_random(460, 1'b0);
    wait_drained();

    send_idle_pct = 86;
    recv_idle_pct = 32;
    send_random(480, 1'b0);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(490, 1'b1);
    wait_drained();
    repeat (END_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests: %0d ok, %0d on empty, %0d not found, %0d refused when full.",
             sent_total, sb.status_seen[STATUS_OK], sb.status_seen[STATUS_EMPTY],
             sb.status_seen[STATUS_NOT_FOUND], sb.status_seen[STATUS_FULL]);
    $display("Checked %0d results, peak occupancy %0d, %0d mismatches.",
             sb.checked, sb.peak_count, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
